// ----- src/adc_request_scan_sequencer_top_defines.svh -----
// assertion macros for the adc request scan sequencer
// used by the top level and the serial divider; expects clk and arst_n in scope
`ifndef ADC_REQUEST_SCAN_SEQUENCER_TOP_DEFINES_SVH
`define ADC_REQUEST_SCAN_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTH
`define ADCSS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ADCSS_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ADCSS_ASSERT(name, prop, msg)
`define ADCSS_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ----- src/adcss_pkg.sv -----
// shared types, codes and constants of the adc request scan sequencer
// no dependencies; imported by the serial divider and the top level
package adcss_pkg;

	localparam int ACTION_W = 2;
	localparam int PORT_W   = 4;
	localparam int SAMPLE_W = 10;
	localparam int CHAN_W   = 5;
	localparam int OWNER_W  = 8;
	localparam int STATUS_W = 2;
	localparam int VALUE_W  = 16;

	// scaling by 1024 before the divide
	localparam int SCALE_SHIFT = 10;
	localparam int DIVIDEND_W  = SAMPLE_W + SCALE_SHIFT;

	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 40;

	localparam int NUM_PORTS_DEF       = 16;
	localparam int BANDGAP_PORT_DEF    = 14;
	localparam int GROUND_PORT_DEF     = 15;
	localparam int RSSI_PORT_DEF       = 0;
	localparam int BANDGAP_CHANNEL_DEF = 30;
	localparam int GROUND_CHANNEL_DEF  = 31;

	localparam logic [SAMPLE_W-1:0] REF_RESET  = 10'd381;
	localparam logic [OWNER_W-1:0]  NULL_OWNER = 8'hFF;
	localparam logic [VALUE_W-1:0]  VALUE_SAT  = 16'hFFFF;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SINGLE = 2'd0,
		ACT_CONT   = 2'd1,
		ACT_DONE   = 2'd2,
		ACT_BIND   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK         = 2'd0,
		STS_BUSY       = 2'd1,
		STS_INVALID    = 2'd2,
		STS_UNEXPECTED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DIV,
		S_EMIT
	} seq_state_t;

	typedef struct packed {
		logic                start;
		logic [SAMPLE_W-1:0] sample;
		logic [SAMPLE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [VALUE_W-1:0] quotient;
	} div_stat_t;

endpackage

// ----- src/adcss_div.sv -----
// restoring serial divider: (sample << 10) / divisor, one quotient bit per cycle
// depends on adcss_pkg and the assertion macro header
`include "adc_request_scan_sequencer_top_defines.svh"

module adcss_div import adcss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_req_t  req,
	output div_stat_t stat
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [SAMPLE_W-1:0]   rem_q;
	logic [SAMPLE_W-1:0]   dsor_q;
	logic [DIVIDEND_W-1:0] quo_q;

	logic [SAMPLE_W:0]     trial;
	logic [SAMPLE_W:0]     diff;
	logic                  fits;
	logic [SAMPLE_W-1:0]   rem_nxt;

	// shift in the next dividend bit and try a subtract
	always_comb begin
		trial   = {rem_q, quo_q[DIVIDEND_W-1]};
		diff    = trial - {1'b0, dsor_q};
		fits    = (trial >= {1'b0, dsor_q});
		rem_nxt = fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q  <= {req.sample, {SCALE_SHIFT{1'b0}}};
			rem_q  <= '0;
			dsor_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= rem_nxt;
		end
	end

	assign stat.done     = done_q;
	assign stat.quotient = quo_q[VALUE_W-1:0];

	`ADCSS_ASSERT(a_div_no_restart, req.start |-> !busy_q, "divider restarted while busy")
	`ADCSS_ASSERT(a_div_done_after_last, done_q |-> $past(busy_q && (cnt_q == '0)), "divider done without last step")

endmodule

// ----- src/adc_request_scan_sequencer_top.sv -----
// adc request scan sequencer: request bookkeeping, round-robin scan, scaled report
// depends on adcss_pkg, adcss_div and the assertion macro header
// sequence: a request, bind or idle completion word goes from accept through exec to emit;
//   other completions pass through the round-robin scan first and, when scaled, the serial divider
// flow: one word at a time, accepted again in the cycle after its result loads the output reg
// reset: async active low; masks, current port cleared, reference 381, default maps, null owners
`include "adc_request_scan_sequencer_top_defines.svh"

module adc_request_scan_sequencer_top import adcss_pkg::*; #(
	parameter int NUM_PORTS       = NUM_PORTS_DEF,
	parameter int BANDGAP_PORT    = BANDGAP_PORT_DEF,
	parameter int GROUND_PORT     = GROUND_PORT_DEF,
	parameter int RSSI_PORT       = RSSI_PORT_DEF,
	parameter int BANDGAP_CHANNEL = BANDGAP_CHANNEL_DEF,
	parameter int GROUND_CHANNEL  = GROUND_CHANNEL_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// port[3:0], sample[13:4], mux_channel[18:14], owner_id[26:19], zeros above
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// action[1:0]
	input  logic [ACTION_W-1:0]   s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// start_valid[0], start_channel[5:1], ready_valid[6], ready_port[10:7],
	// ready_value[26:11], ready_owner[34:27], zeros above
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// status[1:0]
	output logic [STATUS_W-1:0]   m_axis_tuser
);

	localparam int PW = $clog2(NUM_PORTS);
	localparam int PAD_W = OUT_DATA_W - (1 + CHAN_W + 1 + PORT_W + VALUE_W + OWNER_W);

	// sequencer
	seq_state_t state_q, state_nxt;

	// block state
	logic [NUM_PORTS-1:0] pend_q;
	logic [NUM_PORTS-1:0] cont_q;
	logic [PW-1:0]        cur_port_q;
	logic [SAMPLE_W-1:0]  ref_q;
	logic [CHAN_W-1:0]    chan_map_q  [NUM_PORTS];
	logic [OWNER_W-1:0]   owner_map_q [NUM_PORTS];

	// captured word
	action_t              act_q;
	logic [PORT_W-1:0]    port_q;
	logic [SAMPLE_W-1:0]  sample_q;
	logic [CHAN_W-1:0]    bchan_q;
	logic [OWNER_W-1:0]   bowner_q;

	// working registers of a completion
	logic [PW-1:0]        done_port_q;
	logic [PW-1:0]        scan_q;

	// result being built
	status_t              r_status_q;
	logic                 r_sv_q;
	logic [CHAN_W-1:0]    r_sch_q;
	logic                 r_rv_q;
	logic [PORT_W-1:0]    r_rport_q;
	logic [VALUE_W-1:0]   r_rval_q;
	logic [OWNER_W-1:0]   r_rown_q;

	// output register
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic [STATUS_W-1:0]   m_user_q;

	// decode
	logic                 port_ok;
	logic                 port_fixed;
	logic [PW-1:0]        pidx;
	logic [PW-1:0]        scan_nxt;
	logic                 scan_end;
	logic                 scan_hit;
	logic [PW-1:0]        chan_rd_idx;
	logic [CHAN_W-1:0]    chan_rd;
	logic                 done_is_rssi;
	logic                 done_is_bg;
	logic                 cur_is_rssi;
	logic                 cur_is_bg;
	logic                 need_div;
	logic                 out_free;
	logic                 emit_load;
	logic                 accept;

	div_req_t             div_req;
	div_stat_t            div_stat;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;

	always_comb begin
		port_ok    = ({1'b0, port_q} < (PORT_W + 1)'(NUM_PORTS));
		port_fixed = (port_q == PORT_W'(BANDGAP_PORT)) || (port_q == PORT_W'(GROUND_PORT));
		pidx       = port_q[PW-1:0];
		// round-robin step with wrap at the last port
		scan_nxt   = (scan_q == PW'(NUM_PORTS - 1)) ? '0 : scan_q + 1'b1;
		scan_hit   = (pend_q != '0) && pend_q[scan_nxt];
		scan_end   = (pend_q == '0) || pend_q[scan_nxt];
		// single read port on the channel map
		chan_rd_idx = (state_q == S_SCAN) ? scan_nxt : pidx;
		chan_rd     = chan_map_q[chan_rd_idx];
		cur_is_rssi  = (PORT_W'(cur_port_q) == PORT_W'(RSSI_PORT));
		cur_is_bg    = (PORT_W'(cur_port_q) == PORT_W'(BANDGAP_PORT));
		done_is_rssi = (PORT_W'(done_port_q) == PORT_W'(RSSI_PORT));
		done_is_bg   = (PORT_W'(done_port_q) == PORT_W'(BANDGAP_PORT));
		need_div     = !done_is_rssi && !done_is_bg && (ref_q != '0);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				if (act_q == ACT_DONE && pend_q != '0) state_nxt = S_SCAN;
				else state_nxt = S_EMIT;
			end
			S_SCAN: begin
				if (scan_end) state_nxt = need_div ? S_DIV : S_EMIT;
			end
			S_DIV: begin
				if (div_stat.done) state_nxt = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready  = (state_q == S_IDLE);
		emit_load      = (state_q == S_EMIT) && out_free;
		div_req.start  = (state_q == S_SCAN) && scan_end && need_div;
		div_req.sample = sample_q;
		div_req.divisor = ref_q;
	end

	adcss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat)
	);

	// control and mapping state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pend_q     <= '0;
			cont_q     <= '0;
			cur_port_q <= '0;
			ref_q      <= REF_RESET;
			m_valid_q  <= 1'b0;
			for (int i = 0; i < NUM_PORTS; i++) begin
				// ground is checked before bandgap, so it wins if they coincide
				if (i == GROUND_PORT) chan_map_q[i] <= CHAN_W'(GROUND_CHANNEL);
				else if (i == BANDGAP_PORT) chan_map_q[i] <= CHAN_W'(BANDGAP_CHANNEL);
				else chan_map_q[i] <= CHAN_W'(i);
				owner_map_q[i] <= NULL_OWNER;
			end
		end else begin
			state_q <= state_nxt;
			if (emit_load) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;

			if (state_q == S_EXEC) begin
				case (act_q)
					ACT_SINGLE, ACT_CONT: begin
						if (port_ok && !pend_q[pidx]) begin
							pend_q[pidx] <= 1'b1;
							if (act_q == ACT_CONT) cont_q[pidx] <= 1'b1;
							// nothing was running: this port starts at once
							if (pend_q == '0) cur_port_q <= pidx;
						end
					end
					ACT_BIND: begin
						if (port_ok && !port_fixed) begin
							chan_map_q[pidx]  <= bchan_q;
							owner_map_q[pidx] <= bowner_q;
						end
					end
					ACT_DONE: begin
						if (pend_q != '0) begin
							if (cur_is_bg) ref_q <= sample_q;
							// continuous ports stay pending
							if (!cont_q[cur_port_q]) pend_q[cur_port_q] <= 1'b0;
						end
					end
					default: ;
				endcase
			end

			if (state_q == S_SCAN && scan_hit) cur_port_q <= scan_nxt;
		end
	end

	// word capture, result assembly, output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= action_t'(s_axis_tuser);
			port_q   <= s_axis_tdata[PORT_W-1:0];
			sample_q <= s_axis_tdata[PORT_W +: SAMPLE_W];
			bchan_q  <= s_axis_tdata[PORT_W + SAMPLE_W +: CHAN_W];
			bowner_q <= s_axis_tdata[PORT_W + SAMPLE_W + CHAN_W +: OWNER_W];
		end

		case (state_q)
			S_EXEC: begin
				r_status_q  <= STS_OK;
				r_sv_q      <= 1'b0;
				r_sch_q     <= '0;
				r_rv_q      <= 1'b0;
				r_rport_q   <= '0;
				r_rval_q    <= '0;
				r_rown_q    <= '0;
				done_port_q <= cur_port_q;
				scan_q      <= cur_port_q;
				case (act_q)
					ACT_SINGLE, ACT_CONT: begin
						if (!port_ok) begin
							r_status_q <= STS_INVALID;
						end else if (pend_q[pidx]) begin
							r_status_q <= STS_BUSY;
						end else if (pend_q == '0) begin
							r_sv_q  <= 1'b1;
							r_sch_q <= chan_rd;
						end
					end
					ACT_BIND: begin
						if (!port_ok || port_fixed) r_status_q <= STS_INVALID;
					end
					ACT_DONE: begin
						if (pend_q == '0) begin
							r_status_q <= STS_UNEXPECTED;
						end else if (cur_is_rssi || !cur_is_bg) begin
							// rssi goes out raw, a zero reference saturates
							r_rv_q    <= 1'b1;
							r_rport_q <= PORT_W'(cur_port_q);
							r_rown_q  <= owner_map_q[cur_port_q];
							if (cur_is_rssi) r_rval_q <= VALUE_W'(sample_q);
							else r_rval_q <= VALUE_SAT;
						end
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				scan_q <= scan_nxt;
				if (scan_hit) begin
					r_sv_q  <= 1'b1;
					r_sch_q <= chan_rd;
				end
			end
			S_DIV: begin
				if (div_stat.done) r_rval_q <= div_stat.quotient;
			end
			default: ;
		endcase

		if (emit_load) begin
			m_data_q <= {{PAD_W{1'b0}}, r_rown_q, r_rval_q, r_rport_q, r_rv_q, r_sch_q, r_sv_q};
			m_user_q <= r_status_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	`ADCSS_ASSERT(a_cont_is_pending, (cont_q & ~pend_q) == '0, "continuous port not pending")
	`ADCSS_ASSERT(a_ref_only_on_done, !$stable(ref_q) |-> $past(state_q == S_EXEC && act_q == ACT_DONE), "reference changed outside a completion")
	`ADCSS_ASSERT(a_div_nonzero_ref, div_req.start |-> (ref_q != '0), "divide started with zero reference")

endmodule

// ----- bench/tb.sv -----
// self-checking bench for the adc request scan sequencer top level
// needs adcss_pkg and adc_request_scan_sequencer_top; predicts every result word in-line
`timescale 1ns / 100ps

module tb;
	import adcss_pkg::*;

	localparam int NPORT       = NUM_PORTS_DEF;
	localparam int BG_PORT     = BANDGAP_PORT_DEF;
	localparam int GND_PORT    = GROUND_PORT_DEF;
	localparam int RSSI_PORT   = RSSI_PORT_DEF;
	localparam int BG_CHAN     = BANDGAP_CHANNEL_DEF;
	localparam int GND_CHAN    = GROUND_CHANNEL_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 60;
	localparam int MAX_REPORTS = 10;

	// one request, completion or bind as the sender sees it
	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic [PORT_W-1:0]   port;
		logic [SAMPLE_W-1:0] sample;
		logic [CHAN_W-1:0]   chan;
		logic [OWNER_W-1:0]  owner;
	} scan_word_t;

	// one result word, unpacked
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                start_v;
		logic [CHAN_W-1:0]   start_ch;
		logic                rdy_v;
		logic [PORT_W-1:0]   rdy_port;
		logic [VALUE_W-1:0]  rdy_value;
		logic [OWNER_W-1:0]  rdy_owner;
	} scan_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [ACTION_W-1:0]   s_axis_tuser = ACT_SINGLE;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]   m_axis_tuser;

	adc_request_scan_sequencer_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow copy of the sequencer state
	logic [NPORT-1:0]    pend_mask;
	logic [NPORT-1:0]    cont_mask;
	logic [PORT_W-1:0]   cur_port;
	logic [SAMPLE_W-1:0] ref_level;
	logic [CHAN_W-1:0]   chan_map [NPORT];
	logic [OWNER_W-1:0]  owner_map [NPORT];

	scan_word_t   pending_words [$];
	scan_result_t expected_reports [$];

	int   mismatch_count = 0;
	int   cont_left = 0;
	int   cycle_count = 0;
	logic quiet = 1'b0;
	logic hold_req = 1'b0;
	logic hold_started = 1'b0;
	int   hold_left = 0;
	logic [3:0] send_gap = '0;
	logic [3:0] recv_gap = '0;
	scan_word_t cur_word = '0;

	task automatic reset_shadow();
		int i;
		pend_mask = '0;
		cont_mask = '0;
		cur_port  = '0;
		ref_level = REF_RESET;
		for (i = 0; i < NPORT; i++) begin
			chan_map[i]  = CHAN_W'(i);
			owner_map[i] = NULL_OWNER;
		end
		chan_map[BG_PORT]  = CHAN_W'(BG_CHAN);
		chan_map[GND_PORT] = CHAN_W'(GND_CHAN);
	endtask

	// advance the shadow state by one word and work out its result word
	task automatic predict_sequencer(input scan_word_t w, output scan_result_t r);
		logic [PORT_W-1:0]     fin;
		logic [DIVIDEND_W-1:0] scaled;
		logic                  hit;
		int                    nxt;
		int                    n;
		r = '0;
		r.status = STS_OK;
		if (w.act == ACT_SINGLE || w.act == ACT_CONT) begin
			if (int'(w.port) >= NPORT) begin
				r.status = STS_INVALID;
			end else if (pend_mask[w.port]) begin
				// busy: continuous mark left alone
				r.status = STS_BUSY;
			end else begin
				if (pend_mask == '0) begin
					r.start_v  = 1'b1;
					r.start_ch = chan_map[w.port];
					cur_port   = w.port;
				end
				pend_mask[w.port] = 1'b1;
				if (w.act == ACT_CONT)
					cont_mask[w.port] = 1'b1;
			end
		end else if (w.act == ACT_BIND) begin
			if (int'(w.port) >= NPORT || int'(w.port) == BG_PORT ||
			    int'(w.port) == GND_PORT) begin
				r.status = STS_INVALID;
			end else begin
				chan_map[w.port]  = w.chan;
				owner_map[w.port] = w.owner;
			end
		end else if (pend_mask == '0) begin
			r.status = STS_UNEXPECTED;
		end else begin
			fin = cur_port;
			if (int'(fin) == BG_PORT)
				ref_level = w.sample;
			if (!cont_mask[fin])
				pend_mask[fin] = 1'b0;
			if (pend_mask != '0) begin
				// round-robin search starting after the finished port
				nxt = int'(fin);
				hit = 1'b0;
				for (n = 0; n < NPORT; n++) begin
					if (!hit) begin
						nxt = (nxt + 1 >= NPORT) ? 0 : nxt + 1;
						hit = pend_mask[nxt];
					end
				end
				cur_port   = PORT_W'(nxt);
				r.start_v  = 1'b1;
				r.start_ch = chan_map[nxt];
			end
			if (int'(fin) == RSSI_PORT) begin
				r.rdy_v     = 1'b1;
				r.rdy_value = VALUE_W'(w.sample);
			end else if (int'(fin) != BG_PORT) begin
				r.rdy_v = 1'b1;
				if (ref_level == '0) begin
					r.rdy_value = VALUE_SAT;
				end else begin
					scaled      = DIVIDEND_W'(w.sample) << SCALE_SHIFT;
					r.rdy_value = VALUE_W'(scaled / DIVIDEND_W'(ref_level));
				end
			end
			if (r.rdy_v) begin
				r.rdy_port  = fin;
				r.rdy_owner = owner_map[fin];
			end
		end
	endtask

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			if (mismatch_count < MAX_REPORTS)
				$display("tb: %s mismatch, expected %0d, got %0d", field, want, got);
			mismatch_count++;
		end
	endtask

	task automatic queue_word(input logic [ACTION_W-1:0] a, input int p, input int smp,
	                          input int ch, input int own);
		scan_word_t w;
		w.act    = a;
		w.port   = PORT_W'(p);
		w.sample = SAMPLE_W'(smp);
		w.chan   = CHAN_W'(ch);
		w.owner  = OWNER_W'(own);
		pending_words.push_back(w);
	endtask

	// mostly requests and completions so the scan keeps several ports in flight
	task automatic queue_random(input int count, input bit allow_cont);
		int k;
		int roll;
		int smp;
		logic [ACTION_W-1:0] a;
		for (k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			smp  = $urandom_range(0, 1023);
			if ($urandom_range(0, 9) == 0)
				smp = $urandom_range(0, 1) ? 1023 : 0;
			if (roll < 40) begin
				a = ACT_SINGLE;
			end else if (roll < 80) begin
				a = ACT_DONE;
			end else if (roll < 95) begin
				a = ACT_BIND;
			end else if (allow_cont && cont_left > 0) begin
				a = ACT_CONT;
				cont_left--;
			end else begin
				a = ACT_SINGLE;
			end
			queue_word(a, $urandom_range(0, 15), smp, $urandom_range(0, 31),
			           $urandom_range(0, 255));
		end
	endtask

	task automatic wait_drain();
		while (pending_words.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
			@(posedge clk);
	endtask

	// driver: predicts on accept, then offers the next queued word or idles
	always @(posedge clk or negedge arst_n) begin : drive
		scan_result_t res;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap      <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_sequencer(cur_word, res);
				expected_reports.push_back(res);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap != '0) begin
					send_gap      <= send_gap - 1'b1;
					s_axis_tvalid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 9) == 0) begin
					send_gap      <= 4'($urandom_range(0, 14));
					s_axis_tvalid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					cur_word      = pending_words.pop_front();
					s_axis_tdata  <= IN_DATA_W'({cur_word.owner, cur_word.chan,
					                             cur_word.sample, cur_word.port});
					s_axis_tuser  <= cur_word.act;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, requested once by the stimulus
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left    <= 0;
			hold_started <= 1'b0;
		end else if (hold_req && !hold_started) begin
			hold_left    <= HOLD_CYCLES;
			hold_started <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor: compare each accepted result word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : monitor
		scan_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap      <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_reports.size() == 0) begin
					if (mismatch_count < MAX_REPORTS)
						$display("tb: result word with nothing expected, tdata %h",
						         m_axis_tdata);
					mismatch_count++;
				end else begin
					want = expected_reports.pop_front();
					check_field("status", want.status, m_axis_tuser);
					check_field("start_valid", want.start_v, m_axis_tdata[0]);
					check_field("start_channel", want.start_ch, m_axis_tdata[5:1]);
					check_field("ready_valid", want.rdy_v, m_axis_tdata[6]);
					check_field("ready_port", want.rdy_port, m_axis_tdata[10:7]);
					check_field("ready_value", want.rdy_value, m_axis_tdata[26:11]);
					check_field("ready_owner", want.rdy_owner, m_axis_tdata[34:27]);
				end
			end
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
			end else if (recv_gap != '0) begin
				recv_gap      <= recv_gap - 1'b1;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				recv_gap      <= 4'($urandom_range(0, 14));
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		reset_shadow();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: idle completion, fixed-port binds, busy, scan order,
		// zero reference, truncated quotient, calibration, raw rssi
		queue_word(ACT_DONE, 3, 5, 0, 0);
		queue_word(ACT_BIND, BG_PORT, 0, 3, 7);
		queue_word(ACT_BIND, GND_PORT, 0, 4, 8);
		queue_word(ACT_BIND, 3, 0, 31, 0);
		queue_word(ACT_BIND, RSSI_PORT, 0, 0, 8'hA5);
		queue_word(ACT_BIND, 12, 0, 21, 255);
		queue_word(ACT_SINGLE, 3, 0, 0, 0);
		queue_word(ACT_SINGLE, 3, 0, 0, 0);
		queue_word(ACT_SINGLE, RSSI_PORT, 0, 0, 0);
		queue_word(ACT_SINGLE, BG_PORT, 0, 0, 0);
		queue_word(ACT_SINGLE, GND_PORT, 0, 0, 0);
		queue_word(ACT_DONE, 0, 1023, 0, 0);
		queue_word(ACT_DONE, 0, 0, 0, 0);
		queue_word(ACT_DONE, 0, 700, 0, 0);
		queue_word(ACT_DONE, 0, 1023, 0, 0);
		queue_word(ACT_SINGLE, BG_PORT, 0, 0, 0);
		queue_word(ACT_DONE, 0, 1, 0, 0);
		queue_word(ACT_SINGLE, 7, 0, 0, 0);
		queue_word(ACT_DONE, 0, 1023, 0, 0);
		queue_word(ACT_SINGLE, BG_PORT, 0, 0, 0);
		queue_word(ACT_DONE, 0, 381, 0, 0);
		queue_word(ACT_SINGLE, 12, 0, 0, 0);
		queue_word(ACT_DONE, 0, 512, 0, 0);
		wait_drain();

		// random traffic; receiver holds off early so the input backs up
		queue_random(700, 1'b0);
		@(posedge clk);
		hold_req <= 1'b1;
		wait_drain();

		// sender pause above, then more traffic
		queue_random(300, 1'b0);
		wait_drain();

		// continuous marks persist, so they come only after the idle cases
		queue_word(ACT_SINGLE, 6, 0, 0, 0);
		queue_word(ACT_CONT, 6, 0, 0, 0);
		queue_word(ACT_DONE, 0, 200, 0, 0);
		queue_word(ACT_CONT, 6, 0, 0, 0);
		queue_word(ACT_DONE, 0, 300, 0, 0);
		queue_word(ACT_CONT, BG_PORT, 0, 0, 0);
		queue_word(ACT_DONE, 0, 400, 0, 0);
		queue_word(ACT_DONE, 0, 381, 0, 0);
		queue_word(ACT_DONE, 0, 1023, 0, 0);
		wait_drain();

		cont_left = 4;
		queue_random(620, 1'b1);
		// last stretch runs without idling on either side
		while (pending_words.size() > 200)
			@(posedge clk);
		quiet <= 1'b1;
		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_reports.size() != 0) begin
			$display("tb: %0d result words never arrived", expected_reports.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
